// ----- hw/rtl/p2f_pkg.sv -----
// ---------------------------------------------------------------------------
// p2f_pkg - shared types and constants for the PCM to float32 converter
// Holds format codes, register indexes and the inter-stage structs.
// ---------------------------------------------------------------------------
package p2f_pkg;

    // format tags
    localparam logic [1:0] FMT_PCM   = 2'd0;
    localparam logic [1:0] FMT_FLOAT = 2'd1;

    // register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_BITS   = 2'd1;
    localparam logic [1:0] REG_ALIGN  = 2'd2;

    // conversion modes decided in stage one
    localparam logic [1:0] MODE_ZERO = 2'd0;  // +0.0 result
    localparam logic [1:0] MODE_PASS = 2'd1;  // float pass-through
    localparam logic [1:0] MODE_CONV = 2'd2;  // integer conversion

    // stage 1 -> stage 2
    typedef struct packed {
        logic [1:0]  mode;
        logic        bad;
        logic        last;
        logic        neg;
        logic [31:0] mag;   // magnitude, or raw bits in pass mode
        logic [4:0]  k;     // scale exponent
    } t_s1;

    // stage 2 -> stage 3
    typedef struct packed {
        logic [1:0]  mode;
        logic        bad;
        logic        last;
        logic        neg;
        logic [31:0] mag;   // normalised so the leading one sits at bit 31
        logic [4:0]  p;     // position of the leading one
        logic [4:0]  k;
    } t_s2;

endpackage

// ----- hw/rtl/p2f_decode.sv -----
// ---------------------------------------------------------------------------
// p2f_decode - format decode and sign/magnitude extraction
// Chooses the conversion mode and forms the magnitude of the sample.
// ---------------------------------------------------------------------------
module p2f_decode import p2f_pkg::*; (
    input  logic [1:0]  i_format,
    input  logic [5:0]  i_bits,
    input  logic [7:0]  i_align,
    input  logic [31:0] i_raw,
    input  logic        i_silent,
    input  logic        i_last,
    output t_s1         o_s1
);
    logic [31:0] v;

    always_comb begin
        o_s1      = '0;
        o_s1.last = i_last;
        v         = '0;
        if (i_silent) begin
            o_s1.mode = MODE_ZERO;
        end else if (i_format == FMT_FLOAT && i_bits == 6'd32) begin
            o_s1.mode = MODE_PASS;
            o_s1.mag  = i_raw;
        end else if (i_format != FMT_PCM) begin
            o_s1.bad = 1'b1;
        end else if (i_bits < 6'd8 || i_align == 8'd0) begin
            o_s1.bad = 1'b1;
        end else begin
            case (i_bits)
                6'd8: begin
                    v = {24'd0, i_raw[7:0]} - 32'd128;
                    o_s1.k = 5'd7;
                    o_s1.mode = MODE_CONV;
                end
                6'd16: begin
                    v = {{16{i_raw[15]}}, i_raw[15:0]};
                    o_s1.k = 5'd15;
                    o_s1.mode = MODE_CONV;
                end
                6'd24: begin
                    v = {{8{i_raw[23]}}, i_raw[23:0]};
                    o_s1.k = 5'd23;
                    o_s1.mode = MODE_CONV;
                end
                6'd32: begin
                    v = i_raw;
                    o_s1.k = 5'd31;
                    o_s1.mode = MODE_CONV;
                end
                default: o_s1.mode = MODE_ZERO;
            endcase
            o_s1.neg = v[31];
            o_s1.mag = v[31] ? (32'd0 - v) : v;
        end
    end
endmodule

// ----- hw/rtl/p2f_normalise.sv -----
// ---------------------------------------------------------------------------
// p2f_normalise - leading-one search and left alignment
// Finds the top set bit of the magnitude and shifts it to bit 31.
// ---------------------------------------------------------------------------
module p2f_normalise import p2f_pkg::*; (
    input  t_s1 i_s1,
    output t_s2 o_s2
);
    logic [4:0] lz;

    // leading-zero count by priority scan
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_s1.mag[i]) lz = 5'(31 - i);
        end
    end

    always_comb begin
        o_s2.mode = i_s1.mode;
        o_s2.bad  = i_s1.bad;
        o_s2.last = i_s1.last;
        o_s2.neg  = i_s1.neg;
        o_s2.k    = i_s1.k;
        o_s2.p    = 5'd31 - lz;
        o_s2.mag  = (i_s1.mode == MODE_CONV) ? (i_s1.mag << lz) : i_s1.mag;
        // zero magnitude converts to +0.0
        if (i_s1.mode == MODE_CONV && i_s1.mag == 32'd0) begin
            o_s2.mode = MODE_ZERO;
        end
    end
endmodule

// ----- hw/rtl/p2f_round.sv -----
// ---------------------------------------------------------------------------
// p2f_round - mantissa rounding and float assembly
// Rounds the aligned magnitude to 24 bits, nearest-even, and packs.
// ---------------------------------------------------------------------------
module p2f_round import p2f_pkg::*; (
    input  t_s2         i_s2,
    output logic [31:0] o_float,
    output logic        o_bad,
    output logic        o_last
);
    logic        rnd;
    logic [24:0] keep;
    logic [7:0]  expo;

    always_comb begin
        // guard at bit 7, sticky below, lsb at bit 8
        rnd  = i_s2.mag[7] && ((i_s2.mag[6:0] != 7'd0) || i_s2.mag[8]);
        keep = {1'b0, i_s2.mag[31:8]} + {24'd0, rnd};
        expo = 8'd127 + {3'd0, i_s2.p} - {3'd0, i_s2.k} + {7'd0, keep[24]};
        o_bad  = i_s2.bad;
        o_last = i_s2.last;
        case (i_s2.mode)
            MODE_PASS: o_float = i_s2.mag;
            MODE_CONV: o_float = {i_s2.neg, expo,
                                  keep[24] ? keep[23:1] : keep[22:0]};
            default:   o_float = 32'd0;
        endcase
    end
endmodule

// ----- hw/rtl/pcm_to_float32_converter.sv -----
// ---------------------------------------------------------------------------
// pcm_to_float32_converter - PCM sample to IEEE single precision
// Three-stage pipeline: decode, normalise, round and pack.
// ---------------------------------------------------------------------------
// Accepts one sample per cycle while the output is not stalled; the three
// register stages are decode, leading-one alignment and rounding. A
// stalled output holds the pipeline; registers should be written only
// while the pipeline is empty.
module pcm_to_float32_converter import p2f_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample_raw,
    input  logic        i_silent,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_float_bits,
    output logic        o_unsupported,
    output logic        o_last_out
);
    logic [1:0]  r_format;
    logic [5:0]  r_bits;
    logic [7:0]  r_align;
    logic        r_v1, r_v2, r_v3;
    t_s1         n_s1, r_s1;
    t_s2         n_s2, r_s2;
    logic [31:0] n_float;
    logic        n_bad, n_last;
    logic        adv3, adv2, adv1;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_PCM;
            r_bits   <= 6'd16;
            r_align  <= 8'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FORMAT: r_format <= i_cfg_data[1:0];
                REG_BITS:   r_bits   <= i_cfg_data[5:0];
                REG_ALIGN:  r_align  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // stall control: a stage moves when the one ahead is free or moving
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    p2f_decode u_dec (
        .i_format(r_format), .i_bits(r_bits), .i_align(r_align),
        .i_raw(i_sample_raw), .i_silent(i_silent), .i_last(i_last_in),
        .o_s1(n_s1)
    );
    p2f_normalise u_norm (.i_s1(r_s1), .o_s2(n_s2));
    p2f_round u_rnd (
        .i_s2(r_s2), .o_float(n_float), .o_bad(n_bad), .o_last(n_last)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) begin
            o_float_bits  <= n_float;
            o_unsupported <= n_bad;
            o_last_out    <= n_last;
        end
    end

    assign o_valid = r_v3;

`ifndef NO_ASSERTIONS
    // a stalled result keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_float_bits))
        else $error("result changed under stall");
    // unsupported results carry +0.0
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unsupported |-> o_float_bits == 32'd0)
        else $error("unsupported result not zero");
    // an accepted item reaches stage one
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted item lost");
`endif

endmodule

// ----- dv/pcm_to_float32_checker.sv -----
// ---------------------------------------------------------------------------
// pcm_to_float32_checker - scoreboard for the PCM to float32 converter
// Watches the config, sample and result channels, predicts each result
// from the sample and the shadow registers, and compares field by field.
// ---------------------------------------------------------------------------
module pcm_to_float32_checker import p2f_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_sample_raw,
    input  logic        i_silent,
    input  logic        i_last_in,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_float_bits,
    input  logic        i_unsupported,
    input  logic        i_last_out,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] fbits;
        logic        unsup;
        logic        last;
    } t_conv_res;

    logic [1:0] shadow_format;
    logic [5:0] shadow_bits;
    logic [7:0] shadow_align;
    // expected results in transfer order, as a circular store
    t_conv_res  exp_mem[64];
    int         wr_cnt;
    int         rd_cnt;

    assign o_pending = wr_cnt - rd_cnt;

    // sign/magnitude over 2^k to single precision, round to nearest-even
    function automatic logic [31:0] scaled_to_f32(logic neg, logic [31:0] mag,
                                                  int unsigned k);
        int          lead;
        int          sh;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] mant;
        logic [7:0]  expo;
        lead = 31;
        if (mag == 0) return 32'h0;
        while (!mag[lead]) lead--;
        if (lead > 23) begin
            sh   = lead - 23;
            rem  = mag & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == 32'h0100_0000) begin
                mant = mant >> 1;
                lead++;
            end
        end else begin
            mant = mag << (23 - lead);
        end
        expo = 8'(lead + 127 - k);
        return {neg, expo, mant[22:0]};
    endfunction

    function automatic logic [31:0] twos_to_f32(logic [31:0] v, int unsigned k);
        if (v[31]) return scaled_to_f32(1'b1, 32'd0 - v, k);
        return scaled_to_f32(1'b0, v, k);
    endfunction

    function automatic t_conv_res convert_sample(logic [31:0] raw, logic sil,
                                                 logic lst);
        t_conv_res r;
        r.fbits = '0;
        r.unsup = 1'b0;
        r.last  = lst;
        if (sil) begin
            r.fbits = '0;
        end else if (shadow_format == FMT_FLOAT && shadow_bits == 6'd32) begin
            r.fbits = raw;
        end else if (shadow_format != FMT_PCM) begin
            r.unsup = 1'b1;
        end else if (shadow_bits < 6'd8 || shadow_align == 8'd0) begin
            r.unsup = 1'b1;
        end else if (shadow_bits == 6'd8) begin
            r.fbits = twos_to_f32({24'd0, raw[7:0]} - 32'd128, 7);
        end else if (shadow_bits == 6'd16) begin
            r.fbits = twos_to_f32({{16{raw[15]}}, raw[15:0]}, 15);
        end else if (shadow_bits == 6'd24) begin
            r.fbits = twos_to_f32({{8{raw[23]}}, raw[23:0]}, 23);
        end else if (shadow_bits == 6'd32) begin
            r.fbits = twos_to_f32(raw, 31);
        end
        return r;
    endfunction

    // monitor all channels on the rising edge
    always @(posedge i_clk) begin
        t_conv_res want;
        if (!i_rst_n) begin
            shadow_format <= FMT_PCM;
            shadow_bits   <= 6'd16;
            shadow_align  <= 8'd2;
            wr_cnt        <= 0;
            rd_cnt        <= 0;
            o_fail_count  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FORMAT: shadow_format <= i_cfg_data[1:0];
                    REG_BITS:   shadow_bits   <= i_cfg_data[5:0];
                    REG_ALIGN:  shadow_align  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) begin
                exp_mem[wr_cnt[5:0]] <= convert_sample(i_sample_raw, i_silent,
                                                       i_last_in);
                wr_cnt <= wr_cnt + 1;
            end
            if (i_res_valid && i_res_ready) begin
                if (wr_cnt == rd_cnt) begin
                    $display("%0t: unexpected result, expected none, got %h/%b/%b",
                             $time, i_float_bits, i_unsupported, i_last_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = exp_mem[rd_cnt[5:0]];
                    rd_cnt <= rd_cnt + 1;
                    if (want.fbits !== i_float_bits || want.unsup !== i_unsupported
                        || want.last !== i_last_out) begin
                        $display("%0t: mismatch, expected %h/%b/%b, got %h/%b/%b",
                                 $time, want.fbits, want.unsup, want.last,
                                 i_float_bits, i_unsupported, i_last_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb - testbench top for the PCM to float32 converter
// Drives directed and random samples across register settings with random
// idling on both sides; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
    import p2f_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_FORMAT;
    logic [7:0]  cfg_data = '0;
    logic        smp_valid = 1'b0;
    logic        smp_ready;
    logic [31:0] smp_raw = '0;
    logic        smp_silent = 1'b0;
    logic        smp_last = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_bits;
    logic        res_unsup;
    logic        res_last;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #10 i_clk = ~i_clk;

    pcm_to_float32_converter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(smp_valid), .o_ready(smp_ready),
        .i_sample_raw(smp_raw), .i_silent(smp_silent), .i_last_in(smp_last),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_float_bits(res_bits), .o_unsupported(res_unsup), .o_last_out(res_last)
    );

    pcm_to_float32_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(smp_valid), .i_ready_in(smp_ready),
        .i_sample_raw(smp_raw), .i_silent(smp_silent), .i_last_in(smp_last),
        .i_res_valid(res_valid), .i_res_ready(res_ready),
        .i_float_bits(res_bits), .i_unsupported(res_unsup), .i_last_out(res_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls at random, changing on the falling edge
    always @(negedge i_clk)
        res_ready <= ($urandom_range(99) >= recv_stall_pct);

    // one register write while the pipeline is empty; valid is left high
    // so that writes can follow back to back
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_format(logic [1:0] fmt, logic [5:0] nbits, logic [7:0] align);
        write_reg(REG_FORMAT, {6'd0, fmt});
        write_reg(REG_BITS, {2'd0, nbits});
        write_reg(REG_ALIGN, align);
        cfg_valid <= 1'b0;
    endtask

    // one sample transfer, with random idle cycles ahead of it; valid is
    // dropped only while idling or draining
    task automatic send_sample(logic [31:0] raw, logic sil, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_valid  <= 1'b1;
        smp_raw    <= raw;
        smp_silent <= sil;
        smp_last   <= lst;
        @(posedge i_clk);
        while (!smp_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait until the result of every accepted sample has been taken, then idle
    task automatic drain();
        smp_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // raw values biased to the edges of each width
    function automatic logic [31:0] pick_raw();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'h7fff_ffc0 | $urandom_range(63);
            5: return {8'($urandom_range(255)), 24'h0} | (32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] edge_vals[12];
        int          k;
        int          phase;
        edge_vals = '{32'h0, 32'h7f, 32'h80, 32'hff, 32'h7fff, 32'h8000, 32'hffff,
                      32'h7f_ffff, 32'h80_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'hffff_ffff};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset format first, then each width at its extremes
        for (k = 0; k < 4; k++) send_sample(edge_vals[k * 3 + 2], 1'b0, k[0]);
        drain();
        set_format(FMT_PCM, 6'd32, 8'd4);
        send_sample(32'h7fff_ffff, 1'b0, 1'b0);
        send_sample(32'h7fff_ffc0, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b1);
        send_sample(32'h0, 1'b0, 1'b0);
        send_sample(32'hffff_ffff, 1'b1, 1'b1);
        drain();
        set_format(FMT_PCM, 6'd8, 8'd1);
        send_sample(32'h0, 1'b0, 1'b0);
        send_sample(32'h80, 1'b0, 1'b0);
        send_sample(32'hff, 1'b0, 1'b1);
        drain();
        set_format(FMT_PCM, 6'd24, 8'd255);
        send_sample(32'h80_0000, 1'b0, 1'b0);
        send_sample(32'h7f_ffff, 1'b0, 1'b0);
        drain();
        set_format(FMT_FLOAT, 6'd32, 8'd4);
        send_sample(32'hbf80_0000, 1'b0, 1'b1);
        send_sample(32'hffff_ffff, 1'b0, 1'b0);
        drain();
        set_format(2'd3, 6'd63, 8'd0);
        send_sample(32'h1234_5678, 1'b0, 1'b0);
        send_sample(32'h1234_5678, 1'b1, 1'b0);
        drain();

        // random: a setting per block, idling phase cycling through all four
        for (phase = 0; phase < 60; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            case ($urandom_range(9))
                0: set_format(FMT_FLOAT, 6'd32, 8'($urandom_range(1, 255)));
                1: set_format(2'($urandom_range(1, 3)), 6'($urandom), 8'($urandom));
                2: set_format(FMT_PCM, 6'($urandom_range(0, 7)), 8'($urandom));
                3: set_format(FMT_PCM, 6'($urandom_range(8, 63)), 8'($urandom));
                4: set_format(FMT_PCM, 6'd8, 8'd0);
                default: set_format(FMT_PCM, 6'(8 * $urandom_range(1, 4)),
                                    8'($urandom_range(1, 255)));
            endcase
            for (k = 0; k < 30; k++)
                send_sample(pick_raw(), ($urandom_range(15) == 0), $urandom_range(1));
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
